// ===== src/ihs_pkg.sv =====
`timescale 1ns / 1ps
package ihs_pkg;

  localparam int WORD_W = 32;
  localparam int PC_W   = 5;
  localparam int OP_W   = 5;
  localparam int CND_W  = 4;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
  localparam logic [OP_W-1:0] OP_INIT   = 5'd2;
  localparam logic [OP_W-1:0] OP_BSET   = 5'd3;
  localparam logic [OP_W-1:0] OP_RDTOP  = 5'd4;
  localparam logic [OP_W-1:0] OP_HELD   = 5'd5;
  localparam logic [OP_W-1:0] OP_RDC    = 5'd6;
  localparam logic [OP_W-1:0] OP_LDA    = 5'd7;
  localparam logic [OP_W-1:0] OP_LDB    = 5'd8;
  localparam logic [OP_W-1:0] OP_WRUP   = 5'd9;
  localparam logic [OP_W-1:0] OP_WRHELD = 5'd10;
  localparam logic [OP_W-1:0] OP_SINIT  = 5'd11;
  localparam logic [OP_W-1:0] OP_RD0    = 5'd12;
  localparam logic [OP_W-1:0] OP_RDI    = 5'd13;
  localparam logic [OP_W-1:0] OP_W0     = 5'd14;
  localparam logic [OP_W-1:0] OP_WI     = 5'd15;
  localparam logic [OP_W-1:0] OP_EINIT  = 5'd16;
  localparam logic [OP_W-1:0] OP_ERD    = 5'd17;
  localparam logic [OP_W-1:0] OP_EOUT   = 5'd18;
  localparam logic [OP_W-1:0] OP_EEND   = 5'd19;

  // branch conditions: jump to target when true, else fall through
  localparam logic [CND_W-1:0] C_NEXT    = 4'd0;
  localparam logic [CND_W-1:0] C_JUMP    = 4'd1;
  localparam logic [CND_W-1:0] C_NOTLAST = 4'd2;
  localparam logic [CND_W-1:0] C_SMALL   = 4'd3;
  localparam logic [CND_W-1:0] C_IZERO   = 4'd4;
  localparam logic [CND_W-1:0] C_CGT     = 4'd5;
  localparam logic [CND_W-1:0] C_NOTGT   = 4'd6;
  localparam logic [CND_W-1:0] C_SORTPH  = 4'd7;
  localparam logic [CND_W-1:0] C_OUTBUSY = 4'd8;
  localparam logic [CND_W-1:0] C_MORE    = 4'd9;

  // program addresses
  localparam logic [PC_W-1:0] A_LOAD    = 5'd0;
  localparam logic [PC_W-1:0] A_INIT    = 5'd1;
  localparam logic [PC_W-1:0] A_BCHK    = 5'd2;
  localparam logic [PC_W-1:0] A_BSET    = 5'd3;
  localparam logic [PC_W-1:0] A_SIFT    = 5'd4;
  localparam logic [PC_W-1:0] A_HELD    = 5'd5;
  localparam logic [PC_W-1:0] A_SCHK    = 5'd6;
  localparam logic [PC_W-1:0] A_RDC     = 5'd7;
  localparam logic [PC_W-1:0] A_LDA     = 5'd8;
  localparam logic [PC_W-1:0] A_LDB     = 5'd9;
  localparam logic [PC_W-1:0] A_CMP     = 5'd10;
  localparam logic [PC_W-1:0] A_WRUP    = 5'd11;
  localparam logic [PC_W-1:0] A_SEND    = 5'd12;
  localparam logic [PC_W-1:0] A_RET     = 5'd13;
  localparam logic [PC_W-1:0] A_RETB    = 5'd14;
  localparam logic [PC_W-1:0] A_SINIT   = 5'd15;
  localparam logic [PC_W-1:0] A_SCHKI   = 5'd16;
  localparam logic [PC_W-1:0] A_RD0     = 5'd17;
  localparam logic [PC_W-1:0] A_RDI     = 5'd18;
  localparam logic [PC_W-1:0] A_W0      = 5'd19;
  localparam logic [PC_W-1:0] A_WI      = 5'd20;
  localparam logic [PC_W-1:0] A_EINIT   = 5'd21;
  localparam logic [PC_W-1:0] A_ERD     = 5'd22;
  localparam logic [PC_W-1:0] A_EOUT    = 5'd23;
  localparam logic [PC_W-1:0] A_EEND    = 5'd24;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CND_W-1:0] cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_JUMP, target: A_LOAD};
    case (pc)
      A_LOAD:  w = '{op: OP_LOAD,   cond: C_NOTLAST, target: A_LOAD};
      A_INIT:  w = '{op: OP_INIT,   cond: C_SMALL,   target: A_EINIT};
      A_BCHK:  w = '{op: OP_NOP,    cond: C_IZERO,   target: A_SINIT};
      A_BSET:  w = '{op: OP_BSET,   cond: C_NEXT,    target: A_LOAD};
      A_SIFT:  w = '{op: OP_RDTOP,  cond: C_NEXT,    target: A_LOAD};
      A_HELD:  w = '{op: OP_HELD,   cond: C_NEXT,    target: A_LOAD};
      A_SCHK:  w = '{op: OP_NOP,    cond: C_CGT,     target: A_SEND};
      A_RDC:   w = '{op: OP_RDC,    cond: C_NEXT,    target: A_LOAD};
      A_LDA:   w = '{op: OP_LDA,    cond: C_NEXT,    target: A_LOAD};
      A_LDB:   w = '{op: OP_LDB,    cond: C_NEXT,    target: A_LOAD};
      A_CMP:   w = '{op: OP_NOP,    cond: C_NOTGT,   target: A_SEND};
      A_WRUP:  w = '{op: OP_WRUP,   cond: C_JUMP,    target: A_SCHK};
      A_SEND:  w = '{op: OP_WRHELD, cond: C_NEXT,    target: A_LOAD};
      A_RET:   w = '{op: OP_NOP,    cond: C_SORTPH,  target: A_SCHKI};
      A_RETB:  w = '{op: OP_NOP,    cond: C_JUMP,    target: A_BCHK};
      A_SINIT: w = '{op: OP_SINIT,  cond: C_NEXT,    target: A_LOAD};
      A_SCHKI: w = '{op: OP_NOP,    cond: C_IZERO,   target: A_EINIT};
      A_RD0:   w = '{op: OP_RD0,    cond: C_NEXT,    target: A_LOAD};
      A_RDI:   w = '{op: OP_RDI,    cond: C_NEXT,    target: A_LOAD};
      A_W0:    w = '{op: OP_W0,     cond: C_NEXT,    target: A_LOAD};
      A_WI:    w = '{op: OP_WI,     cond: C_JUMP,    target: A_SIFT};
      A_EINIT: w = '{op: OP_EINIT,  cond: C_NEXT,    target: A_LOAD};
      A_ERD:   w = '{op: OP_ERD,    cond: C_OUTBUSY, target: A_ERD};
      A_EOUT:  w = '{op: OP_EOUT,   cond: C_MORE,    target: A_ERD};
      A_EEND:  w = '{op: OP_EEND,   cond: C_JUMP,    target: A_LOAD};
      default: w = '{op: OP_NOP,    cond: C_JUMP,    target: A_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== src/ihs_item_if.sv =====
`timescale 1ns / 1ps
interface ihs_item_if;
  import ihs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] value;
  logic                     last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

// ===== src/ihs_result_if.sv =====
`timescale 1ns / 1ps
interface ihs_result_if;
  import ihs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] sorted_value;
  logic                     final_res;
  logic                     overflowed;

  modport source (output valid, output sorted_value, output final_res, output overflowed,
                  input ready);
  modport sink (input valid, input sorted_value, input final_res, input overflowed,
                output ready);
endinterface

// ===== src/ihs_ram.sv =====
`timescale 1ns / 1ps
module ihs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/integer_heap_sorter.sv =====
`timescale 1ns / 1ps
// channel  modport  payload                                  transfer
// items    sink     value[31:0] signed, last                 valid && ready
// results  source   sorted_value[31:0] signed, final_res,    valid && ready
//                   overflowed
//
// Loading accepts one item per cycle. After last, heap build and sort run on a
// one-read, one-write element RAM; each sift level costs six program steps,
// and each result then takes a read step and an output step.
// Synchronous reset returns the program to the load step with an empty set.
// A stalled result holds the emit loop; the next set is accepted while the
// final result of a run is still waiting.
module integer_heap_sorter #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  ihs_item_if.sink     items,
  ihs_result_if.source results
);
  import ihs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [PC_W-1:0]          pc;
  logic [PC_W-1:0]          pc_next;
  ctrl_t                    cw;
  logic                     take;
  logic [CW-1:0]            cnt;
  logic                     ovf;
  logic [CW-1:0]            n;
  logic [CW-1:0]            k;
  logic [AW-1:0]            i;
  logic [AW-1:0]            top;
  logic [AW:0]              child;
  logic [AW-1:0]            last_idx;
  logic                     phase;
  logic signed [WORD_W-1:0] a;
  logic signed [WORD_W-1:0] held;
  logic                     xfer;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [WORD_W-1:0]        wdata;
  logic [AW-1:0]            raddr;
  logic [WORD_W-1:0]        rdata;

  ihs_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cw = ucode(pc);
  assign items.ready = (cw.op == OP_LOAD);
  assign xfer = items.valid && items.ready;

  always_comb begin
    case (cw.cond)
      C_NEXT:    take = 1'b0;
      C_JUMP:    take = 1'b1;
      C_NOTLAST: take = !(xfer && items.last);
      C_SMALL:   take = (cnt < CW'(2));
      C_IZERO:   take = (i == '0);
      C_CGT:     take = (child > {1'b0, last_idx});
      C_NOTGT:   take = !(a > held);
      C_SORTPH:  take = phase;
      C_OUTBUSY: take = results.valid && !results.ready;
      C_MORE:    take = (CW'(k + 1'b1) != n);
      default:   take = 1'b0;
    endcase
    pc_next = take ? cw.target : PC_W'(pc + 1'b1);
  end

  always_comb begin
    we    = 1'b0;
    waddr = top;
    wdata = a;
    raddr = top;
    case (cw.op)
      OP_LOAD: begin
        we    = xfer && (cnt < CW'(DEPTH));
        waddr = cnt[AW-1:0];
        wdata = items.value;
      end
      OP_WRUP:   we = 1'b1;
      OP_WRHELD: begin
        we    = 1'b1;
        wdata = held;
      end
      OP_W0: begin
        we    = 1'b1;
        waddr = '0;
        wdata = rdata;
      end
      OP_WI: begin
        we    = 1'b1;
        waddr = i;
      end
      OP_RDC:  raddr = child[AW-1:0];
      OP_LDA:  raddr = AW'(child + 1'b1);
      OP_RD0:  raddr = '0;
      OP_RDI:  raddr = i;
      OP_ERD:  raddr = k[AW-1:0];
      default: raddr = top;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= A_LOAD;
      cnt           <= '0;
      ovf           <= 1'b0;
      phase         <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      case (cw.op)
        OP_LOAD: begin
          if (xfer) begin
            if (cnt < CW'(DEPTH)) begin
              cnt <= CW'(cnt + 1'b1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        OP_INIT: begin
          n <= cnt;
          i <= AW'(cnt >> 1);
        end
        OP_BSET: begin
          i        <= AW'(i - 1'b1);
          top      <= AW'(i - 1'b1);
          last_idx <= AW'(n - 1'b1);
          phase    <= 1'b0;
        end
        OP_RDTOP: child <= {top, 1'b1};
        OP_HELD:  held <= rdata;
        OP_LDA:   a <= rdata;
        OP_LDB: begin
          if ((child < {1'b0, last_idx}) && ($signed(rdata) > a)) begin
            child <= (AW + 1)'(child + 1'b1);
            a     <= rdata;
          end
        end
        OP_WRUP: begin
          top   <= child[AW-1:0];
          child <= {child[AW-1:0], 1'b1};
        end
        OP_SINIT: begin
          i     <= AW'(n - 1'b1);
          phase <= 1'b1;
        end
        OP_RDI: a <= rdata;
        OP_WI: begin
          top      <= '0;
          last_idx <= AW'(i - 1'b1);
          i        <= AW'(i - 1'b1);
        end
        OP_EINIT: k <= '0;
        OP_EOUT: begin
          results.valid        <= 1'b1;
          results.sorted_value <= rdata;
          results.final_res    <= (CW'(k + 1'b1) == n);
          results.overflowed   <= ovf;
          k                    <= CW'(k + 1'b1);
        end
        OP_EEND: begin
          cnt <= '0;
          ovf <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EOUT) |-> !results.valid)
    else $error("result register loaded while occupied");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("element count beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (cnt == CW'(DEPTH)))
    else $error("overflow flagged with store not full");

  a_child_range: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_RDC) |-> (child <= {1'b0, last_idx}))
    else $error("child read outside heap");

  a_load_after_final: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EEND) |=> (pc == A_LOAD) && (cnt == '0))
    else $error("run end did not return to load with empty set");

endmodule

// ===== sim/integer_heap_sorter_tb.sv =====
`timescale 1ns / 1ps
module integer_heap_sorter_tb;
  import ihs_pkg::*;

  localparam int SET_CAP = 64;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     last;
  } set_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflowed;
  } sorted_word_t;

  logic clk = 1'b0;
  logic rst;

  ihs_item_if   items_ch();
  ihs_result_if results_ch();

  integer_heap_sorter #(
    .DEPTH(SET_CAP)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_item_t                pending[$];
  logic signed [WORD_W-1:0] held_values[$];
  logic                     dropped_flag = 1'b0;
  sorted_word_t             sorted_due[$];

  int items_total    = 0;
  int items_accepted = 0;
  int sets_closed    = 0;
  int overflow_sets  = 0;
  int results_seen   = 0;
  int errors         = 0;

  // predictor: append or drop, and on last sort the held set ascending
  function automatic void take_item(logic signed [WORD_W-1:0] v, logic is_last);
    logic signed [WORD_W-1:0] key;
    int                       i;
    int                       j;
    sorted_word_t             w;
    if (held_values.size() < SET_CAP) begin
      held_values.push_back(v);
    end else begin
      dropped_flag = 1'b1;
    end
    if (is_last) begin
      for (i = 1; i < held_values.size(); i++) begin
        key = held_values[i];
        j = i - 1;
        while (j >= 0 && held_values[j] > key) begin
          held_values[j+1] = held_values[j];
          j--;
        end
        held_values[j+1] = key;
      end
      for (i = 0; i < held_values.size(); i++) begin
        w.sorted_value = held_values[i];
        w.final_res    = (i == held_values.size() - 1);
        w.overflowed   = dropped_flag;
        sorted_due.push_back(w);
      end
      sets_closed++;
      if (dropped_flag) begin
        overflow_sets++;
      end
      held_values.delete();
      dropped_flag = 1'b0;
    end
  endfunction

  function automatic logic signed [WORD_W-1:0] draw_value();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      6, 7: draw_value = int'($urandom_range(0, 8)) - 4;
      8: draw_value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      9: begin
        draw_value = 32'sd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1)) begin
          draw_value = ~draw_value;
        end
      end
      default: draw_value = $urandom;
    endcase
  endfunction

  task automatic push_item(input logic signed [WORD_W-1:0] v, input logic is_last);
    pending.push_back('{value: v, last: is_last});
  endtask

  task automatic push_random_set(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      push_item(draw_value(), k == n - 1);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  set_item_t next_item;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      items_ch.valid <= 1'b0;
    end else begin
      if (items_ch.valid && items_ch.ready) begin
        take_item(items_ch.value, items_ch.last);
        items_accepted++;
      end
      if (!items_ch.valid || items_ch.ready) begin
        if (gap_left != 0 || pending.size() == 0) begin
          items_ch.valid <= 1'b0;
          if (gap_left != 0) begin
            gap_left--;
          end
        end else begin
          next_item = pending.pop_front();
          items_ch.valid <= 1'b1;
          items_ch.value <= next_item.value;
          items_ch.last  <= next_item.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: stall pattern of its own plus one long hold-off
  int ready_mode  = 0;
  int phase_left  = 0;
  int hold_cycles = 0;
  int drained     = 0;
  bit hold_done   = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        drained++;
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        results_ch.ready <= 1'b0;
      end else if (!hold_done && results_ch.valid && drained >= 30) begin
        hold_done   = 1'b1;
        hold_cycles = HOLD_OFF_CYCLES;
        results_ch.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          ready_mode = $urandom_range(0, 2);
          phase_left = $urandom_range(10, 60);
        end else begin
          phase_left--;
        end
        case (ready_mode)
          0: results_ch.ready <= 1'b1;
          1: results_ch.ready <= 1'($urandom_range(0, 1));
          default: results_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor
  sorted_word_t want;

  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      results_seen++;
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual value %0d final %0b ovf %0b",
                 $time, results_ch.sorted_value, results_ch.final_res, results_ch.overflowed);
        errors++;
      end else begin
        want = sorted_due.pop_front();
        if (results_ch.sorted_value !== want.sorted_value) begin
          $display("%0t: sorted_value mismatch, expected %0d actual %0d",
                   $time, want.sorted_value, results_ch.sorted_value);
          errors++;
        end
        if (results_ch.final_res !== want.final_res) begin
          $display("%0t: final_res mismatch, expected %0b actual %0b",
                   $time, want.final_res, results_ch.final_res);
          errors++;
        end
        if (results_ch.overflowed !== want.overflowed) begin
          $display("%0t: overflowed mismatch, expected %0b actual %0b",
                   $time, want.overflowed, results_ch.overflowed);
          errors++;
        end
      end
    end
  end

  initial begin
    int random_items;
    int n;
    bit big_done;
    rst = 1'b1;

    // single element
    push_item(32'sh8000_0000, 1'b1);
    // two elements, extremes
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(32'sh8000_0000, 1'b1);
    // sign boundaries
    push_item(32'sd0, 1'b0);
    push_item(-32'sd1, 1'b0);
    push_item(32'sd1, 1'b0);
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh4000_0000, 1'b0);
    push_item(-32'sd2, 1'b1);
    // duplicates
    push_item(32'sd5, 1'b0);
    push_item(32'sd5, 1'b0);
    push_item(-32'sd5, 1'b0);
    push_item(32'sd5, 1'b0);
    push_item(-32'sd5, 1'b1);
    // already ascending
    push_item(-32'sd3, 1'b0);
    push_item(-32'sd2, 1'b0);
    push_item(-32'sd1, 1'b0);
    push_item(32'sd0, 1'b0);
    push_item(32'sd1, 1'b0);
    push_item(32'sd2, 1'b1);

    // small sets, one oversized set whose closing item is itself dropped
    random_items = 0;
    big_done     = 1'b0;
    while (random_items < 90) begin
      if (!big_done && random_items >= 20) begin
        n = $urandom_range(SET_CAP + 2, SET_CAP + 4);
        big_done = 1'b1;
      end else begin
        n = $urandom_range(1, 12);
      end
      push_random_set(n);
      random_items += n;
    end
    items_total = pending.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted != items_total) @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d sets from %0d items, %0d sorted transfers checked,",
             sets_closed, items_accepted, results_seen);
    $display("%0d set(s) past capacity, one long receiver hold-off.", overflow_sets);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d transfers still due", $time, sorted_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
